// File: hw/rtl/fixed_block_free_list_allocator_assert.svh
// Assertion macros used by the checker of the block allocator.
// Each expects clk and rst to be visible where it is used.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FBAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fbal_pkg.sv
`default_nettype none

package fbal_pkg;

  localparam int CMD_W      = 2;
  localparam int INDEX_W    = 8;
  localparam int OFFSET_W   = 21;
  localparam int COUNT_W    = 9;
  localparam int STATUS_W   = 2;
  localparam int RAW_W      = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int STRIDE_W   = 14;
  localparam int RAW_MAX    = 4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_BLOCK_BYTES = 1'd0,
    CFG_BLOCK_COUNT     = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/fbal_req_if.sv
`default_nettype none

interface fbal_req_if
  import fbal_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [INDEX_W-1:0] free_index;

  modport source (output valid, output cmd, output free_index, input ready);
  modport sink   (input valid, input cmd, input free_index, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fbal_rsp_if.sv
`default_nettype none

interface fbal_rsp_if
  import fbal_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  block_index;
  logic [OFFSET_W-1:0] block_offset;
  logic [COUNT_W-1:0]  free_count;
  logic [OFFSET_W-1:0] pool_bytes;

  modport source (output valid, output status, output block_index, output block_offset,
                  output free_count, output pool_bytes, input ready);
  modport sink   (input valid, input status, input block_index, input block_offset,
                  input free_count, input pool_bytes, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fixed_block_free_list_allocator.sv
// Fixed-size block allocator keeping its free blocks as a LIFO list in a link RAM of
// MAX_BLOCKS entries. One command is taken at a time. Free, a rejected command and the
// unused code go from accept to S_FIN, where the result is loaded into the output
// register; allocate passes through S_ALLOC first (the head's link is read from the RAM
// through its registered read port), and init through S_WALK, which writes one link per
// cycle through the single RAM write port. The result sits in an output register, so a
// new command is taken while it waits; that command then stalls until the waiting beat
// is taken. The link RAM has no clearing pass: allocate before the first init or free
// reports an empty pool.
`default_nettype none

module fixed_block_free_list_allocator
  import fbal_pkg::*;
#(
  parameter int MAX_BLOCKS = 256,
  parameter int WORD_BYTES = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  fbal_req_if.sink                   req,
  fbal_rsp_if.source                 rsp,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int PROD_W = IDX_W + STRIDE_W;
  localparam int POOL_W = CNT_W + STRIDE_W;

  localparam logic [CNT_W-1:0]    LIST_END = CNT_W'(MAX_BLOCKS);
  localparam logic [OFFSET_W-1:0] HDR_BYTES = OFFSET_W'(WORD_BYTES);

  logic [RAW_W-1:0]   raw_block_bytes;
  logic [COUNT_W-1:0] block_count;

  state_t              state, state_next;
  logic [CNT_W-1:0]    head, head_next;
  logic [CNT_W-1:0]    free_total, free_total_next;
  logic [IDX_W-1:0]    walk_ctr, walk_ctr_next;
  status_t             res_status, res_status_next;
  logic [IDX_W-1:0]    res_idx, res_idx_next;
  logic                res_has, res_has_next;
  logic [OFFSET_W-1:0] off_prod;
  logic [OFFSET_W-1:0] pool_prod;

  logic                out_valid;
  status_t             out_status;
  logic [INDEX_W-1:0]  out_index;
  logic [OFFSET_W-1:0] out_offset;
  logic [COUNT_W-1:0]  out_count;
  logic [OFFSET_W-1:0] out_pool;
  logic                out_load;

  logic [RAW_W-1:0]    raw_sat;
  logic [STRIDE_W-1:0] stride;
  logic [CMP_W-1:0]    count_ext;
  logic [CNT_W-1:0]    n_eff;
  logic [CMP_W-1:0]    fidx_ext;
  logic [IDX_W-1:0]    mul_idx;
  logic [PROD_W-1:0]   off_mul;
  logic [POOL_W-1:0]   pool_mul;
  logic [CNT_W-1:0]    walk_succ;
  logic                accept;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [CNT_W-1:0]    mem_wdata;
  logic [CNT_W-1:0]    mem_rdata;

  fbal_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (IDX_W'(head)),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_block_bytes <= RAW_W'(8);
      block_count     <= COUNT_W'(256);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_RAW_BLOCK_BYTES: raw_block_bytes <= cfg_data;
        CFG_BLOCK_COUNT:     block_count     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (raw_block_bytes == '0) begin
      raw_sat = RAW_W'(1);
    end else if (raw_block_bytes > RAW_W'(RAW_MAX)) begin
      raw_sat = RAW_W'(RAW_MAX);
    end else begin
      raw_sat = raw_block_bytes;
    end
    stride = (STRIDE_W'(raw_sat) + STRIDE_W'(WORD_BYTES - 1)) & ~STRIDE_W'(WORD_BYTES - 1);

    count_ext = CMP_W'(block_count);
    if (count_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (count_ext > CMP_W'(MAX_BLOCKS)) begin
      n_eff = LIST_END;
    end else begin
      n_eff = CNT_W'(count_ext);
    end
  end

  assign accept    = req.valid && req.ready;
  assign fidx_ext  = CMP_W'(req.free_index);
  assign mul_idx   = (req.cmd == CMD_FREE) ? IDX_W'(req.free_index) : IDX_W'(head);
  assign off_mul   = PROD_W'(mul_idx) * PROD_W'(stride);
  assign pool_mul  = POOL_W'(stride) * POOL_W'(n_eff);
  assign walk_succ = CNT_W'(walk_ctr) + CNT_W'(1);

  always_comb begin
    state_next      = state;
    head_next       = head;
    free_total_next = free_total;
    walk_ctr_next   = walk_ctr;
    res_status_next = res_status;
    res_idx_next    = res_idx;
    res_has_next    = res_has;
    mem_we          = 1'b0;
    mem_waddr       = walk_ctr;
    mem_wdata       = walk_succ;
    out_load        = 1'b0;
    req.ready       = 1'b0;

    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          res_status_next = ST_OK;
          res_idx_next    = '0;
          res_has_next    = 1'b0;
          state_next      = S_FIN;
          unique case (req.cmd)
            CMD_INIT: begin
              walk_ctr_next = '0;
              state_next    = S_WALK;
            end
            CMD_ALLOC: begin
              if (head >= LIST_END) begin
                res_status_next = ST_EMPTY;
              end else begin
                res_idx_next = IDX_W'(head);
                res_has_next = 1'b1;
                state_next   = S_ALLOC;
              end
            end
            CMD_FREE: begin
              if (fidx_ext >= CMP_W'(n_eff)) begin
                res_status_next = ST_RANGE;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = IDX_W'(req.free_index);
                mem_wdata    = head;
                head_next    = CNT_W'(req.free_index);
                res_idx_next = IDX_W'(req.free_index);
                res_has_next = 1'b1;
                if (free_total < n_eff) begin
                  free_total_next = free_total + CNT_W'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        mem_we = 1'b1;
        if (walk_succ == n_eff) begin
          mem_wdata       = LIST_END;
          head_next       = '0;
          free_total_next = n_eff;
          state_next      = S_FIN;
        end else begin
          walk_ctr_next = walk_ctr + IDX_W'(1);
        end
      end
      S_ALLOC: begin
        head_next = mem_rdata;
        if (free_total != '0) begin
          free_total_next = free_total - CNT_W'(1);
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= LIST_END;
      free_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      free_total <= free_total_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_ctr   <= walk_ctr_next;
    res_status <= res_status_next;
    res_idx    <= res_idx_next;
    res_has    <= res_has_next;
    pool_prod  <= OFFSET_W'(pool_mul);
    if (accept) begin
      off_prod <= OFFSET_W'(off_mul);
    end
    if (out_load) begin
      out_status <= res_status;
      out_index  <= INDEX_W'(res_idx);
      out_offset <= res_has ? (off_prod + HDR_BYTES) : '0;
      out_count  <= COUNT_W'(free_total);
      out_pool   <= pool_prod + HDR_BYTES;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.block_index  = out_index;
  assign rsp.block_offset = out_offset;
  assign rsp.free_count   = out_count;
  assign rsp.pool_bytes   = out_pool;

endmodule

`default_nettype wire

// File: hw/rtl/fbal_ram.sv
`default_nettype none

module fbal_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/fbal_checker.sv
`default_nettype none
`include "fixed_block_free_list_allocator_assert.svh"

module fbal_checker
  import fbal_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire logic [STATUS_W-1:0] rsp_status,
  input wire logic [INDEX_W-1:0]  rsp_block_index,
  input wire logic [OFFSET_W-1:0] rsp_block_offset,
  input wire logic [COUNT_W-1:0]  rsp_free_count
);

  // stalled result beat holds
  `FBAL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_block_index) && $stable(rsp_block_offset), "stalled result beat changed")

  // one command in flight
  `FBAL_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "command taken while busy")

  // failed commands carry no block
  `FBAL_ASSERT_NOW(a_fail_no_block, rsp_valid && rsp_status != ST_OK, rsp_block_index == '0 && rsp_block_offset == '0, "failed result names a block")

  // empty pool reports a zero free count
  `FBAL_ASSERT_NOW(a_empty_count, rsp_valid && rsp_status == ST_EMPTY, rsp_free_count == '0, "empty pool with nonzero free count")

endmodule

bind fixed_block_free_list_allocator fbal_checker u_fbal_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_block_index  (rsp.block_index),
  .rsp_block_offset (rsp.block_offset),
  .rsp_free_count   (rsp.free_count)
);

`default_nettype wire

// File: sim/fbal_checker.sv
module fbal_scoreboard
  import fbal_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  fbal_req_if                        req,
  fbal_rsp_if                        rsp,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         outstanding
);

  localparam int POOL_BLOCKS = 256;
  localparam int WORD_BYTES  = 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  block_index;
    logic [OFFSET_W-1:0] block_offset;
    logic [COUNT_W-1:0]  free_count;
    logic [OFFSET_W-1:0] pool_bytes;
  } alloc_result_t;

  logic [RAW_W-1:0]   raw_bytes;
  logic [COUNT_W-1:0] block_count;
  logic [COUNT_W-1:0] head;
  logic [COUNT_W-1:0] free_total;
  logic [COUNT_W-1:0] next_link [POOL_BLOCKS];
  alloc_result_t      expected_results [$];

  function automatic int unsigned stride_bytes();
    int unsigned r;
    r = raw_bytes;
    if (r < 1) r = 1;
    if (r > RAW_MAX) r = RAW_MAX;
    return (r + WORD_BYTES - 1) & ~(32'(WORD_BYTES) - 1);
  endfunction

  function automatic int unsigned active_blocks();
    int unsigned n;
    n = block_count;
    if (n < 1) n = 1;
    if (n > POOL_BLOCKS) n = POOL_BLOCKS;
    return n;
  endfunction

  // Updates the free list shadow and returns the result the command should give.
  function automatic alloc_result_t apply_command(logic [CMD_W-1:0] c,
                                                  logic [INDEX_W-1:0] fidx);
    alloc_result_t res;
    int unsigned   n;
    n   = active_blocks();
    res = '0;
    case (c)
      CMD_INIT: begin
        for (int i = 0; i + 1 < n; i++) next_link[i] = COUNT_W'(i + 1);
        next_link[n - 1] = COUNT_W'(POOL_BLOCKS);
        head       = '0;
        free_total = COUNT_W'(n);
      end
      CMD_ALLOC: begin
        if (head >= POOL_BLOCKS) begin
          res.status = ST_EMPTY;
        end else begin
          res.block_index  = head[INDEX_W-1:0];
          res.block_offset = OFFSET_W'(WORD_BYTES + head * stride_bytes());
          head = next_link[head];
          if (free_total > 0) free_total = free_total - 1'b1;
        end
      end
      CMD_FREE: begin
        if (fidx >= n) begin
          res.status = ST_RANGE;
        end else begin
          next_link[fidx] = head;
          head = {1'b0, fidx};
          if (free_total < n) free_total = free_total + 1'b1;
          res.block_index  = fidx;
          res.block_offset = OFFSET_W'(WORD_BYTES + fidx * stride_bytes());
        end
      end
      default: ;
    endcase
    res.free_count = free_total;
    res.pool_bytes = OFFSET_W'(stride_bytes() * n + WORD_BYTES);
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
  endtask

  always @(posedge clk) begin : watch
    alloc_result_t want;
    if (rst) begin
      raw_bytes   = 13'd8;
      block_count = 9'd256;
      head        = COUNT_W'(POOL_BLOCKS);
      free_total  = '0;
      mismatches  = 0;
      foreach (next_link[i]) next_link[i] = '0;
      expected_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report("beat with nothing expected", rsp.block_index, 0);
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status) report("status", rsp.status, want.status);
          if (rsp.block_index !== want.block_index)
            report("block_index", rsp.block_index, want.block_index);
          if (rsp.block_offset !== want.block_offset)
            report("block_offset", rsp.block_offset, want.block_offset);
          if (rsp.free_count !== want.free_count)
            report("free_count", rsp.free_count, want.free_count);
          if (rsp.pool_bytes !== want.pool_bytes)
            report("pool_bytes", rsp.pool_bytes, want.pool_bytes);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_RAW_BLOCK_BYTES: raw_bytes   = cfg_data[RAW_W-1:0];
          CFG_BLOCK_COUNT:     block_count = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        expected_results.push_back(apply_command(req.cmd, req.free_index));
    end
    outstanding <= expected_results.size();
  end

endmodule

// File: sim/testbench.sv
module testbench;
  import fbal_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_MAX      = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 100;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;
  int                    idle_cycles;
  int unsigned           block_setting;
  bit                    send_gaps;
  bit                    recv_gaps;
  bit                    hold_request;

  fbal_req_if req ();
  fbal_rsp_if rsp ();

  fixed_block_free_list_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fbal_scoreboard result_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before each beat when recv_gaps is set, one long hold-off on request.
  initial begin : result_sink
    int wait_cycles;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        wait_cycles  = HOLD_CYCLES;
      end else begin
        wait_cycles = recv_gaps ? $urandom_range(0, STALL_MAX) : 0;
      end
      if (wait_cycles > 0) begin
        rsp.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rsp.valid && rsp.ready));
    end
  end

  task automatic send_cmd(logic [CMD_W-1:0] c, logic [INDEX_W-1:0] fidx);
    int gap;
    gap = send_gaps ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.cmd        <= c;
    req.free_index <= fidx;
    do @(posedge clk); while (!(req.valid && req.ready));
  endtask

  task automatic settle_idle();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_set(int unsigned raw, int unsigned count);
    cfg_write <= 1'b1;
    cfg_index <= CFG_RAW_BLOCK_BYTES;
    cfg_data  <= CFG_DATA_W'(raw);
    @(posedge clk);
    cfg_index <= CFG_BLOCK_COUNT;
    cfg_data  <= CFG_DATA_W'(count & 9'h1ff);
    @(posedge clk);
    cfg_write <= 1'b0;
    block_setting = count & 9'h1ff;
  endtask

  // Mostly alloc/free traffic on a live list, with the odd re-init and unused command.
  task automatic run_phase(int items, bit start_init);
    int unsigned        n;
    int unsigned        pick;
    logic [CMD_W-1:0]   c;
    logic [INDEX_W-1:0] fidx;
    n = block_setting;
    if (n < 1) n = 1;
    if (n > 256) n = 256;
    if (start_init) send_cmd(CMD_INIT, INDEX_W'($urandom_range(0, 255)));
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) c = CMD_INIT;
      else if (pick < 50) c = CMD_ALLOC;
      else if (pick < 96) c = CMD_FREE;
      else c = CMD_UNUSED;
      if ($urandom_range(0, 99) < 85) fidx = INDEX_W'($urandom_range(0, n - 1));
      else fidx = INDEX_W'($urandom_range(0, 255));
      send_cmd(c, fidx);
    end
  endtask

  initial begin : stimulus
    int unsigned raw;
    int unsigned cnt;
    rst            <= 1'b1;
    cfg_write      <= 1'b0;
    cfg_index      <= CFG_RAW_BLOCK_BYTES;
    cfg_data       <= '0;
    req.valid      <= 1'b0;
    req.cmd        <= CMD_INIT;
    req.free_index <= '0;
    send_gaps      = 1'b1;
    recv_gaps      = 1'b1;
    hold_request   = 1'b0;
    block_setting  = 256;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // use before init, then a plain init at reset settings
    send_cmd(CMD_ALLOC, 8'd0);
    send_cmd(CMD_FREE, 8'd5);
    send_cmd(CMD_ALLOC, 8'd0);
    send_cmd(CMD_ALLOC, 8'd0);
    send_cmd(CMD_UNUSED, 8'd0);
    send_cmd(CMD_INIT, 8'd0);
    send_cmd(CMD_ALLOC, 8'd0);
    send_cmd(CMD_FREE, 8'd255);
    send_cmd(CMD_FREE, 8'd255);
    settle_idle();

    // size below range, tiny pool: drain, range error, double free, saturation
    cfg_set(0, 4);
    send_cmd(CMD_INIT, 8'd0);
    repeat (5) send_cmd(CMD_ALLOC, 8'd0);
    send_cmd(CMD_FREE, 8'd4);
    send_cmd(CMD_FREE, 8'd3);
    send_cmd(CMD_FREE, 8'd3);
    send_cmd(CMD_FREE, 8'd2);
    send_cmd(CMD_FREE, 8'd1);
    send_cmd(CMD_FREE, 8'd0);
    settle_idle();

    // size and count above range saturate
    cfg_set(8191, 511);
    send_cmd(CMD_INIT, 8'd0);
    send_cmd(CMD_FREE, 8'd255);
    settle_idle();

    // count shrunk after init: list keeps blocks beyond the new count
    cfg_set(4096, 2);
    send_cmd(CMD_ALLOC, 8'd0);
    send_cmd(CMD_FREE, 8'd200);
    settle_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin raw = 1;    cnt = 1;   end
        1: begin raw = 4096; cnt = 256; end
        2: begin raw = 8191; cnt = 0;   end
        3: begin raw = 0;    cnt = 511; end
        default: begin
          raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 64);
          cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 12);
        end
      endcase
      send_gaps = (p % 3 != 1);
      recv_gaps = (p % 3 != 1);
      if (p == 5) begin
        send_gaps    = 1'b0;
        hold_request = 1'b1;
      end
      cfg_set(raw, cnt);
      run_phase(PHASE_ITEMS, p % 4 != 3);
      settle_idle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: fixed_block_free_list_allocator.f
+incdir+hw/rtl
hw/rtl/fbal_pkg.sv
hw/rtl/fbal_req_if.sv
hw/rtl/fbal_rsp_if.sv
hw/rtl/fbal_ram.sv
hw/rtl/fixed_block_free_list_allocator.sv
hw/rtl/fbal_checker.sv
sim/fbal_checker.sv
sim/testbench.sv
